@@ rtl/core/volume_exhaustion_detector_defines.svh @@
// ----------------------------------------------------------------------------
// volume_exhaustion_detector_defines
// assertion macros shared by the volume exhaustion detector modules
// ----------------------------------------------------------------------------
`ifndef VOLUME_EXHAUSTION_DETECTOR_DEFINES_SVH
`define VOLUME_EXHAUSTION_DETECTOR_DEFINES_SVH

// same-cycle implication, clocked on aclk, off during reset
`define VED_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define VED_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/ved_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ved_pkg
// types and constants of the volume exhaustion detector
// ----------------------------------------------------------------------------
package ved_pkg;

    localparam int WINDOW_MAX_DEF = 32;

    localparam int VOL_W      = 32;
    localparam int WSIZE_W    = 6;
    localparam int MDEC_W     = 17;
    localparam int MDECL_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int PROD_W     = MDEC_W + VOL_W;

    localparam logic [WSIZE_W-1:0] WSIZE_RST = WSIZE_W'(20);
    localparam logic [MDEC_W-1:0]  MDEC_RST  = MDEC_W'(6554);
    localparam logic [MDECL_W-1:0] MDECL_RST = MDECL_W'(3);

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DECREASE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DECLINES = 2'd2;

    localparam logic ACT_TRADE = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;
    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_WALK,
        ST_DRAIN
    } ved_state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic setup;
        logic issue;
        logic load_out;
    } ved_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last;
        logic busy;
    } ved_stat_t;

    // datapath to each side lane
    typedef struct packed {
        logic push;
        logic clear;
        logic setup;
        logic issue;
        logic first;
    } ved_lane_cmd_t;

endpackage

@@ rtl/core/volume_exhaustion_detector.sv @@
`timescale 1ns / 1ps
// each input transfer goes through setup, the pair walk over the window in use and drain
// a new input transfer is taken only in idle, once the previous result is loaded
// the pair walk makes one ring read per cycle on each side
// a result held in the output register does not block the next input transfer
// reset: synchronous active-low aresetn empties both windows and loads the
// register defaults (window 20, decrease 6554, declines 3)
// ----------------------------------------------------------------------------
// volume_exhaustion_detector
// per-side volume windows flagging runs of consecutive fractional declines
// ----------------------------------------------------------------------------
module volume_exhaustion_detector #(
    parameter int WINDOW_MAX = ved_pkg::WINDOW_MAX_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_action,
    input  logic                           s_side,
    input  logic [ved_pkg::VOL_W-1:0]      s_volume,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_buy_exhausted,
    output logic                           m_sell_exhausted,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ved_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ved_pkg::CFG_DATA_W-1:0] cfg_data
);

    ved_pkg::ved_cmd_t  cmd;
    ved_pkg::ved_stat_t stat;

    assign cfg_ready = 1'b1;

    ved_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .cmd    (cmd),
        .stat   (stat)
    );

    ved_datapath #(
        .WINDOW_MAX(WINDOW_MAX)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_action        (s_action),
        .s_side          (s_side),
        .s_volume        (s_volume),
        .cfg_we          (cfg_valid && cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_buy_exhausted (m_buy_exhausted),
        .m_sell_exhausted(m_sell_exhausted)
    );

endmodule

@@ rtl/core/ved_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ved_lane
// volume ring of one side with the pair walk and its decline run counter
// ----------------------------------------------------------------------------
`include "volume_exhaustion_detector_defines.svh"

module ved_lane #(
    parameter int WINDOW_MAX = ved_pkg::WINDOW_MAX_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ved_pkg::ved_lane_cmd_t        cmd,
    input  logic [ved_pkg::VOL_W-1:0]     volume,
    input  logic [$clog2(WINDOW_MAX+1)-1:0] win,
    input  logic [ved_pkg::MDEC_W-1:0]    min_decrease,
    input  logic [ved_pkg::MDECL_W-1:0]   min_declines,
    output logic                          hit,
    output logic                          busy
);

    localparam int AW    = $clog2(WINDOW_MAX);
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);

    logic [ved_pkg::VOL_W-1:0]  ring_mem [WINDOW_MAX];

    logic [AW-1:0]    head_reg, head_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [AW-1:0]    addr_reg;
    logic [AW-1:0]    start;
    logic [CNT_W-1:0] head_ext;
    logic             fill_ok_reg;

    logic             rd_vld_reg, rd_first_reg, pa_vld_reg;
    logic [ved_pkg::VOL_W-1:0]  rd_data_reg, prev_reg, diff_reg;
    logic [ved_pkg::PROD_W-1:0] prod_reg;
    logic             ok_reg;

    logic [ved_pkg::MDECL_W-1:0] run_reg, run_next;
    logic             hit_reg, hit_next;
    logic             qual;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
        return (a == AW'(WINDOW_MAX - 1)) ? '0 : a + AW'(1);
    endfunction

    // oldest slot of the window, modulo the ring depth
    assign head_ext = CNT_W'(head_reg);
    always_comb begin
        if (head_ext >= win) begin
            start = AW'(head_ext - win);
        end else begin
            start = AW'(CNT_W'(WINDOW_MAX) - win + head_ext);
        end
    end

    always_comb begin
        head_next = head_reg;
        fill_next = fill_reg;
        if (cmd.clear) begin
            head_next = '0;
            fill_next = '0;
        end else if (cmd.push) begin
            head_next = wrap_inc(head_reg);
            if (fill_reg != CNT_W'(WINDOW_MAX)) begin
                fill_next = fill_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            fill_reg <= '0;
        end else begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    // ring memory, registered read
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            ring_mem[head_reg] <= volume;
        end
        if (cmd.issue) begin
            rd_data_reg <= ring_mem[addr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            addr_reg    <= start;
            fill_ok_reg <= (fill_reg >= win);
        end else if (cmd.issue) begin
            addr_reg <= wrap_inc(addr_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg   <= 1'b0;
            rd_first_reg <= 1'b0;
            pa_vld_reg   <= 1'b0;
        end else begin
            rd_vld_reg   <= cmd.issue;
            rd_first_reg <= cmd.issue && cmd.first;
            pa_vld_reg   <= rd_vld_reg && !rd_first_reg;
        end
    end

    // pair stage: min_decrease times prev, and the difference prev minus cur
    always_ff @(posedge aclk) begin
        if (rd_vld_reg) begin
            prev_reg <= rd_data_reg;
        end
        if (rd_vld_reg && !rd_first_reg) begin
            prod_reg <= ved_pkg::PROD_W'(min_decrease) * ved_pkg::PROD_W'(prev_reg);
            diff_reg <= prev_reg - rd_data_reg;
            ok_reg   <= (prev_reg != '0) && (prev_reg >= rd_data_reg);
        end
    end

    // compare stage: (prev-cur)*65536 >= min_decrease*prev
    assign qual = ok_reg && ({1'b0, diff_reg, 16'h0000} >= prod_reg);

    always_comb begin
        run_next = run_reg;
        hit_next = hit_reg;
        if (cmd.setup) begin
            run_next = '0;
            hit_next = 1'b0;
        end else if (pa_vld_reg) begin
            if (qual) begin
                if (run_reg != '1) begin
                    run_next = run_reg + ved_pkg::MDECL_W'(1);
                end
                if (run_next >= min_declines) begin
                    hit_next = 1'b1;
                end
            end else begin
                run_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= '0;
            hit_reg <= 1'b0;
        end else begin
            run_reg <= run_next;
            hit_reg <= hit_next;
        end
    end

    assign hit  = hit_reg && fill_ok_reg;
    assign busy = rd_vld_reg || pa_vld_reg;

    `VED_ASSERT_IMP(a_pair_after_read, pa_vld_reg, $past(rd_vld_reg), "pair stage without read")
    `VED_ASSERT_IMP(a_head_tracks_fill, fill_reg != CNT_W'(WINDOW_MAX), head_ext == fill_reg, "head and fill disagree before saturation")

endmodule

@@ rtl/core/ved_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ved_datapath
// configuration registers, walk counter, both side lanes and result flags
// ----------------------------------------------------------------------------
module ved_datapath #(
    parameter int WINDOW_MAX = ved_pkg::WINDOW_MAX_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ved_pkg::ved_cmd_t                 cmd,
    output ved_pkg::ved_stat_t                stat,
    input  logic                              s_action,
    input  logic                              s_side,
    input  logic [ved_pkg::VOL_W-1:0]         s_volume,
    input  logic                              cfg_we,
    input  logic [ved_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ved_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                              m_buy_exhausted,
    output logic                              m_sell_exhausted
);

    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int CMP_W = (CNT_W > ved_pkg::WSIZE_W) ? CNT_W : ved_pkg::WSIZE_W;

    logic [ved_pkg::WSIZE_W-1:0] window_size_reg;
    logic [ved_pkg::MDEC_W-1:0]  min_decrease_reg;
    logic [ved_pkg::MDECL_W-1:0] min_declines_reg;

    logic [CMP_W-1:0] ws_ext;
    logic [CNT_W-1:0] win;
    logic [CNT_W-1:0] idx_reg;

    logic trade, clear;
    ved_pkg::ved_lane_cmd_t buy_cmd, sell_cmd;
    logic buy_hit, sell_hit, buy_busy, sell_busy;
    logic buy_flag_reg, sell_flag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg  <= ved_pkg::WSIZE_RST;
            min_decrease_reg <= ved_pkg::MDEC_RST;
            min_declines_reg <= ved_pkg::MDECL_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                ved_pkg::REG_WINDOW_SIZE:  window_size_reg  <= cfg_data[ved_pkg::WSIZE_W-1:0];
                ved_pkg::REG_MIN_DECREASE: min_decrease_reg <= cfg_data[ved_pkg::MDEC_W-1:0];
                ved_pkg::REG_MIN_DECLINES: min_declines_reg <= cfg_data[ved_pkg::MDECL_W-1:0];
                default: ;
            endcase
        end
    end

    // window in use: zero counts as one, capped at the ring depth
    assign ws_ext = CMP_W'(window_size_reg);
    always_comb begin
        if (ws_ext == '0) begin
            win = CNT_W'(1);
        end else if (ws_ext > CMP_W'(WINDOW_MAX)) begin
            win = CNT_W'(WINDOW_MAX);
        end else begin
            win = CNT_W'(ws_ext);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
        end else if (cmd.setup) begin
            idx_reg <= '0;
        end else if (cmd.issue) begin
            idx_reg <= idx_reg + CNT_W'(1);
        end
    end

    assign trade = cmd.accept && (s_action == ved_pkg::ACT_TRADE) && (s_volume != '0);
    assign clear = cmd.accept && (s_action == ved_pkg::ACT_CLEAR);

    always_comb begin
        buy_cmd.push  = trade && (s_side == ved_pkg::SIDE_BUY);
        buy_cmd.clear = clear;
        buy_cmd.setup = cmd.setup;
        buy_cmd.issue = cmd.issue;
        buy_cmd.first = (idx_reg == '0);
        sell_cmd      = buy_cmd;
        sell_cmd.push = trade && (s_side == ved_pkg::SIDE_SELL);
    end

    ved_lane #(
        .WINDOW_MAX(WINDOW_MAX)
    ) u_buy_lane (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (buy_cmd),
        .volume      (s_volume),
        .win         (win),
        .min_decrease(min_decrease_reg),
        .min_declines(min_declines_reg),
        .hit         (buy_hit),
        .busy        (buy_busy)
    );

    ved_lane #(
        .WINDOW_MAX(WINDOW_MAX)
    ) u_sell_lane (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (sell_cmd),
        .volume      (s_volume),
        .win         (win),
        .min_decrease(min_decrease_reg),
        .min_declines(min_declines_reg),
        .hit         (sell_hit),
        .busy        (sell_busy)
    );

    assign stat.last = (idx_reg == win - CNT_W'(1));
    assign stat.busy = buy_busy || sell_busy;

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            buy_flag_reg  <= buy_hit;
            sell_flag_reg <= sell_hit;
        end
    end

    assign m_buy_exhausted  = buy_flag_reg;
    assign m_sell_exhausted = sell_flag_reg;

endmodule

@@ rtl/core/ved_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ved_ctrl
// sequencer for accept, window setup, pair walk, drain and result transfer
// ----------------------------------------------------------------------------
`include "volume_exhaustion_detector_defines.svh"

module ved_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    output ved_pkg::ved_cmd_t  cmd,
    input  ved_pkg::ved_stat_t stat
);

    ved_pkg::ved_state_t state_reg, state_next;
    logic m_valid_reg, m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ved_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ved_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ved_pkg::ST_SETUP;
                end
            end
            ved_pkg::ST_SETUP: begin
                cmd.setup  = 1'b1;
                state_next = ved_pkg::ST_WALK;
            end
            ved_pkg::ST_WALK: begin
                cmd.issue = 1'b1;
                if (stat.last) begin
                    state_next = ved_pkg::ST_DRAIN;
                end
            end
            ved_pkg::ST_DRAIN: begin
                // wait for the compare pipe and a free output register
                if (!stat.busy && (!m_valid_reg || m_ready)) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ved_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ved_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

    `VED_ASSERT_NXT(a_one_item, s_valid && s_ready, !s_ready, "second transfer taken mid-item")
    `VED_ASSERT_IMP(a_drain_in_flight, (state_reg == ved_pkg::ST_DRAIN) && $past(state_reg == ved_pkg::ST_WALK), stat.busy, "pipe empty right after walk")

endmodule
